@@ rtl/kar_pkg.sv @@
// Shared types, codes and symbol helpers for the keyword alphabet running cipher.
// Has no dependencies. Used by kar_ctrl, kar_datapath and the top level.
package kar_pkg;

    localparam int SYM_COUNT = 29;
    localparam int SYM_W     = 5;

    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_SEAL = 2'd1;
    localparam logic [1:0] KIND_MSG  = 2'd2;

    localparam logic [SYM_W-1:0] CODE_COMMA  = 5'd26;
    localparam logic [SYM_W-1:0] CODE_PERIOD = 5'd27;
    localparam logic [SYM_W-1:0] CODE_SPACE  = 5'd28;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] code;
    } sym_t;

    typedef struct packed {
        logic key_char;
        logic msg;
        logic seal_start;
        logic seal_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic seal_last;
    } status_t;

    function automatic sym_t sym_code(input logic [7:0] c);
        sym_t s;
        s.hit  = 1'b1;
        s.code = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.code = SYM_W'(c - 8'h41);
        end else if (c == 8'h2C) begin
            s.code = CODE_COMMA;
        end else if (c == 8'h2E) begin
            s.code = CODE_PERIOD;
        end else if (c == 8'h20) begin
            s.code = CODE_SPACE;
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] sym_ascii(input logic [SYM_W-1:0] code);
        logic [7:0] r;
        if (code < CODE_COMMA) begin
            r = 8'h41 + {3'b000, code};
        end else if (code == CODE_COMMA) begin
            r = 8'h2C;
        end else if (code == CODE_PERIOD) begin
            r = 8'h2E;
        end else if (code == CODE_SPACE) begin
            r = 8'h20;
        end else begin
            r = 8'h00;
        end
        return r;
    endfunction

endpackage

@@ rtl/kar_ctrl.sv @@
// Controller state machine: input handshake, message lookup and the seal walk.
// Depends on kar_pkg; drives commands into kar_datapath.
module kar_ctrl
    import kar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    output logic       in_stall,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MSG  = 2'd1;
    localparam logic [1:0] ST_SEAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept) begin
                    unique case (kind)
                        KIND_KEY:
                        begin
                            cmd.key_char = 1'b1;
                        end
                        KIND_SEAL:
                        begin
                            cmd.seal_start = 1'b1;
                            state_next     = ST_SEAL;
                        end
                        KIND_MSG:
                        begin
                            cmd.msg    = 1'b1;
                            state_next = ST_MSG;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MSG:
            begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SEAL:
            begin
                cmd.seal_step = 1'b1;
                if (status.seal_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/kar_datapath.sv @@
// Datapath: key table memory, presence map, key length, running index and output word.
// Depends on kar_pkg; commanded by kar_ctrl.
module kar_datapath
    import kar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       restart,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cipher_char,
    output logic       key_not_ready
);

    logic [SYM_W-1:0]     key_mem [SYM_COUNT];
    logic [SYM_W-1:0]     key_rd_reg;
    logic                 nr_reg;
    logic                 nr_next;

    logic [SYM_W-1:0]     key_length_reg;
    logic [SYM_W-1:0]     key_length_next;
    logic [SYM_COUNT-1:0] present_reg;
    logic [SYM_COUNT-1:0] present_next;
    logic                 sealed_reg;
    logic                 sealed_next;
    logic [SYM_W-1:0]     index_reg;
    logic [SYM_W-1:0]     index_next;
    logic [SYM_W-1:0]     seal_cnt_reg;
    logic [SYM_W-1:0]     seal_cnt_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           cipher_reg;
    logic [7:0]           cipher_next;
    logic                 key_nr_reg;
    logic                 key_nr_next;

    sym_t                 key_sym;
    sym_t                 msg_sym;
    logic                 app_req;
    logic [SYM_W-1:0]     app_code;
    logic                 app_we;
    logic [SYM_W-1:0]     base;
    logic [SYM_W:0]       addend;
    logic [SYM_W:0]       sum;
    logic [SYM_W-1:0]     msg_idx;

    assign key_sym = sym_code(fold_upper(char_in));
    assign msg_sym = sym_code(char_in);

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.seal_last = (seal_cnt_reg == SYM_W'(SYM_COUNT - 1));

    always_comb
    begin
        app_req  = 1'b0;
        app_code = key_sym.code;
        if (cmd.seal_step) begin
            app_req  = 1'b1;
            app_code = seal_cnt_reg;
        end else if (cmd.key_char && !sealed_reg && key_sym.hit) begin
            app_req  = 1'b1;
        end
    end

    assign app_we = app_req && !present_reg[app_code]
                    && (key_length_reg < SYM_W'(SYM_COUNT));

    // running index step, sum stays below twice the symbol count
    assign base    = restart ? '0 : index_reg;
    assign addend  = msg_sym.hit ? ({1'b0, msg_sym.code} + (SYM_W+1)'(1)) : '0;
    assign sum     = {1'b0, base} + addend;
    assign msg_idx = (sum >= (SYM_W+1)'(SYM_COUNT)) ? SYM_W'(sum - (SYM_W+1)'(SYM_COUNT))
                                                    : SYM_W'(sum);

    always_comb
    begin
        key_length_next = key_length_reg;
        present_next    = present_reg;
        sealed_next     = sealed_reg;
        index_next      = index_reg;
        seal_cnt_next   = seal_cnt_reg;
        nr_next         = nr_reg;
        out_valid_next  = out_valid_reg;
        cipher_next     = cipher_reg;
        key_nr_next     = key_nr_reg;

        if (app_we) begin
            key_length_next        = key_length_reg + SYM_W'(1);
            present_next[app_code] = 1'b1;
        end
        if (cmd.seal_start) begin
            seal_cnt_next = '0;
        end else if (cmd.seal_step) begin
            seal_cnt_next = seal_cnt_reg + SYM_W'(1);
            if (status.seal_last) begin
                sealed_next = 1'b1;
            end
        end
        if (cmd.msg) begin
            nr_next = !sealed_reg;
            if (sealed_reg) begin
                index_next = msg_idx;
            end
        end
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            cipher_next    = nr_reg ? 8'h00 : sym_ascii(key_rd_reg);
            key_nr_next    = nr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_we) begin
            key_mem[key_length_reg] <= app_code;
        end
        if (cmd.msg) begin
            key_rd_reg <= key_mem[msg_idx];
        end
        cipher_reg <= cipher_next;
        key_nr_reg <= key_nr_next;
        nr_reg     <= nr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_length_reg <= '0;
            present_reg    <= '0;
            sealed_reg     <= 1'b0;
            index_reg      <= '0;
            seal_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            key_length_reg <= key_length_next;
            present_reg    <= present_next;
            sealed_reg     <= sealed_next;
            index_reg      <= index_next;
            seal_cnt_reg   <= seal_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cipher_char   = cipher_reg;
    assign key_not_ready = key_nr_reg;

endmodule

@@ rtl/keyword_alphabet_running_cipher.sv @@
// Keyword alphabet running cipher, top level.
// A key phrase character or an ignored word is handled in the idle state. A message
// character is handled as the index step with the key table read, then the load of
// the output register, which waits while the output stays stalled. A seal walks
// over the 29 symbols in turn and writes each one not yet present into the key table.
// A finished word waits in the output register while key words keep being taken.
// Depends on kar_pkg, kar_ctrl and kar_datapath.
module keyword_alphabet_running_cipher
    import kar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] char_in,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cipher_char,
    output logic       key_not_ready
);

    cmd_t    cmd;
    status_t status;

    kar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kar_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_in       (char_in),
        .restart       (restart),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_char   (cipher_char),
        .key_not_ready (key_not_ready)
    );

endmodule
